[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked, reset-gated.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/ecc_pkg.sv]
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared types and codes for the elevator car controller.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam logic [1:0] OP_ARRIVAL = 2'd0;
    localparam logic [1:0] OP_HALL    = 2'd1;
    localparam logic [1:0] OP_CABIN   = 2'd2;
    localparam logic [1:0] OP_IDLE    = 2'd3;

    localparam logic [2:0] CMD_STOP     = 3'd0;
    localparam logic [2:0] CMD_OPEN     = 3'd1;
    localparam logic [2:0] CMD_CLOSE    = 3'd2;
    localparam logic [2:0] CMD_UP       = 3'd3;
    localparam logic [2:0] CMD_DOWN     = 3'd4;
    localparam logic [2:0] CMD_LAMP_ON  = 3'd5;
    localparam logic [2:0] CMD_LAMP_OFF = 3'd6;

    localparam logic [1:0] DIR_IDLE = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_DOWN = 2'd2;

    localparam int MAX_CMDS = 5;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] floor;
    } t_in_item;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] lamp_floor;
        logic       last;
    } t_out_item;

    // commands caused by one event
    typedef struct packed {
        logic [MAX_CMDS-1:0][2:0] cmds;
        logic [3:0]               floor;
        logic [2:0]               count;
    } t_cmd_list;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[rtl/ecc_front.sv]
// ----------------------------------------------------------------------------
// ecc_front
// Takes events, keeps floor/direction/stop state, builds the command list.
// ----------------------------------------------------------------------------
module ecc_front import ecc_pkg::*; #(
    parameter int FLOORS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_stall,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_cmd_list o_entry
);

    localparam int         MASK_W = (FLOORS > 16) ? 16 : FLOORS;
    localparam logic [3:0] TOP_F  = 4'(MASK_W - 1);

    logic [3:0]        r_cur_floor, n_cur_floor;
    logic [1:0]        r_dir, n_dir;
    logic [MASK_W-1:0] r_mask, n_mask;

    logic [3:0]        fl;
    logic [MASK_W-1:0] fbit;
    t_cmd_list         lst;
    logic              accept;

    function automatic t_cmd_list push_cmd(t_cmd_list l, logic [2:0] c);
        t_cmd_list r;
        r = l;
        if (r.count < 3'(MAX_CMDS)) begin
            r.cmds[r.count] = c;
            r.count         = r.count + 3'd1;
        end
        return r;
    endfunction

    function automatic logic any_above(logic [MASK_W-1:0] m, logic [3:0] c);
        logic r;
        r = 1'b0;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i] && (4'(i) > c)) r = 1'b1;
        end
        return r;
    endfunction

    function automatic logic any_below(logic [MASK_W-1:0] m, logic [3:0] c);
        logic r;
        r = 1'b0;
        for (int i = 0; i < MASK_W; i++) begin
            if (m[i] && (4'(i) < c)) r = 1'b1;
        end
        return r;
    endfunction

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !o_stall;

    always_comb begin
        n_cur_floor = r_cur_floor;
        n_dir       = r_dir;
        n_mask      = r_mask;
        lst         = '0;
        fl          = (i_item.floor > TOP_F) ? TOP_F : i_item.floor;
        fbit        = MASK_W'(1) << fl;
        lst.floor   = fl;
        unique case (i_item.operation)
            OP_ARRIVAL: begin
                n_cur_floor = fl;
                if ((n_mask & fbit) != '0) begin
                    lst    = push_cmd(lst, CMD_STOP);
                    lst    = push_cmd(lst, CMD_OPEN);
                    n_mask = n_mask & ~fbit;
                    lst    = push_cmd(lst, CMD_LAMP_OFF);
                    if (n_mask == '0) begin
                        lst   = push_cmd(lst, CMD_STOP);
                        n_dir = DIR_IDLE;
                    end else if (n_dir == DIR_UP) begin
                        lst = push_cmd(lst, CMD_CLOSE);
                        if (any_above(n_mask, n_cur_floor)) begin
                            lst = push_cmd(lst, CMD_UP);
                        end else begin
                            n_dir = DIR_DOWN;
                            lst   = push_cmd(lst, CMD_DOWN);
                        end
                    end else if (n_dir == DIR_DOWN) begin
                        lst = push_cmd(lst, CMD_CLOSE);
                        if (any_below(n_mask, n_cur_floor)) begin
                            lst = push_cmd(lst, CMD_DOWN);
                        end else begin
                            n_dir = DIR_UP;
                            lst   = push_cmd(lst, CMD_UP);
                        end
                    end
                end else if (n_dir == DIR_UP) begin
                    lst = push_cmd(lst, CMD_UP);
                end else if (n_dir == DIR_DOWN) begin
                    lst = push_cmd(lst, CMD_DOWN);
                end
            end
            OP_HALL: begin
                n_mask = n_mask | fbit;
                if (n_dir == DIR_IDLE) begin
                    if (fl == n_cur_floor) begin
                        lst = push_cmd(lst, CMD_STOP);
                        lst = push_cmd(lst, CMD_OPEN);
                    end
                    lst = push_cmd(lst, CMD_CLOSE);
                    if (fl > n_cur_floor) begin
                        lst   = push_cmd(lst, CMD_UP);
                        n_dir = DIR_UP;
                    end else begin
                        lst   = push_cmd(lst, CMD_DOWN);
                        n_dir = DIR_DOWN;
                    end
                    lst = push_cmd(lst, CMD_LAMP_ON);
                end else begin
                    lst = push_cmd(lst, CMD_LAMP_ON);
                    if (fl > n_cur_floor) begin
                        lst   = push_cmd(lst, CMD_UP);
                        n_dir = DIR_UP;
                    end else if (fl < n_cur_floor) begin
                        lst   = push_cmd(lst, CMD_DOWN);
                        n_dir = DIR_DOWN;
                    end
                end
            end
            OP_CABIN: begin
                n_mask = n_mask | fbit;
                if (n_dir == DIR_IDLE) begin
                    if (fl > n_cur_floor) begin
                        lst   = push_cmd(lst, CMD_CLOSE);
                        lst   = push_cmd(lst, CMD_LAMP_ON);
                        lst   = push_cmd(lst, CMD_UP);
                        n_dir = DIR_UP;
                    end else if (fl < n_cur_floor) begin
                        lst   = push_cmd(lst, CMD_CLOSE);
                        lst   = push_cmd(lst, CMD_LAMP_ON);
                        lst   = push_cmd(lst, CMD_DOWN);
                        n_dir = DIR_DOWN;
                    end else begin
                        lst = push_cmd(lst, CMD_STOP);
                        lst = push_cmd(lst, CMD_OPEN);
                    end
                end else if (n_dir == DIR_UP) begin
                    lst = push_cmd(lst, CMD_UP);
                    lst = push_cmd(lst, CMD_LAMP_ON);
                end else if (n_dir == DIR_DOWN) begin
                    lst = push_cmd(lst, CMD_DOWN);
                    lst = push_cmd(lst, CMD_LAMP_ON);
                end
            end
            OP_IDLE: begin
            end
        endcase

        // idle start
        if (n_dir == DIR_IDLE && n_mask != '0) begin
            if (any_above(n_mask, n_cur_floor)) begin
                lst   = push_cmd(lst, CMD_CLOSE);
                lst   = push_cmd(lst, CMD_UP);
                n_dir = DIR_UP;
            end else if (any_below(n_mask, n_cur_floor)) begin
                lst   = push_cmd(lst, CMD_CLOSE);
                lst   = push_cmd(lst, CMD_DOWN);
                n_dir = DIR_DOWN;
            end
        end
    end

    assign o_push  = accept && (lst.count != 3'd0);
    assign o_entry = lst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_floor <= '0;
            r_dir       <= DIR_IDLE;
            r_mask      <= '0;
        end else if (accept) begin
            r_cur_floor <= n_cur_floor;
            r_dir       <= n_dir;
            r_mask      <= n_mask;
        end
    end

endmodule

[rtl/ecc_queue.sv]
// ----------------------------------------------------------------------------
// ecc_queue
// Short FIFO of command lists between front and back.
// ----------------------------------------------------------------------------
module ecc_queue import ecc_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd_list i_entry,
    input  logic      i_pop,
    output t_cmd_list o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd_list        r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= next_ptr(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= next_ptr(r_rd_ptr);
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/ecc_back.sv]
// ----------------------------------------------------------------------------
// ecc_back
// Serializes queued command lists onto the registered result channel.
// ----------------------------------------------------------------------------
module ecc_back import ecc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd_list i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_stall
);

    logic [2:0] r_idx;
    logic       r_valid;
    t_out_item  r_item;

    logic       load;
    logic       take;
    logic       is_last;
    logic [2:0] cmd;

    assign load    = !r_valid || !i_stall;
    assign take    = load && !i_q_status.empty;
    assign cmd     = i_head.cmds[r_idx];
    assign is_last = (r_idx == (i_head.count - 3'd1));
    assign o_pop   = take && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_q_status.empty;
            if (take) begin
                r_idx <= is_last ? 3'd0 : r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.command    <= cmd;
            r_item.lamp_floor <= (cmd == CMD_LAMP_ON || cmd == CMD_LAMP_OFF) ?
                                 i_head.floor : 4'd0;
            r_item.last       <= is_last;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/elevator_car_controller.sv]
// ----------------------------------------------------------------------------
// elevator_car_controller
// One elevator car, SCAN-style stop scheduling.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / i_in_data / o_in_stall) takes one event per
// transaction: floor arrival, hall call, cabin call or idle tick. Output
// channel (o_out_valid / o_out_data / i_out_stall) carries motor, door and
// lamp commands, zero to five per event, with last set on the final one.
// An event that produces no command produces no output transaction.
// Each event's command list is written into the command queue as one entry,
// then the output register presents its commands in order. Events are taken
// one per cycle while the command queue (QUEUE_DEPTH events) has room; the
// output side emits one command per cycle while i_out_stall is low, so the
// sustained rate is set by that serializer.
// Reset: the car is at floor 0, idle, with no pending stops, and queue and
// output register are empty. While i_out_stall is high the presented
// command holds; the queue keeps absorbing events until full, then
// o_in_stall rises.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module elevator_car_controller import ecc_pkg::*; #(
    parameter int FLOORS      = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    t_q_status q_status;
    t_cmd_list push_entry;
    t_cmd_list head;
    logic      push;
    logic      pop;

    ecc_front #(
        .FLOORS(FLOORS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .i_item    (i_in_data),
        .o_stall   (o_in_stall),
        .i_q_status(q_status),
        .o_push    (push),
        .o_entry   (push_entry)
    );

    ecc_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_status(q_status)
    );

    ecc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_head    (head),
        .i_q_status(q_status),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .o_item    (o_out_data),
        .i_stall   (i_out_stall)
    );

    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, push, !q_status.full)

    `ASSERT_IMPL(a_lamp_floor_zero, i_clk, i_rst_n,
        o_out_valid && o_out_data.command != CMD_LAMP_ON && o_out_data.command != CMD_LAMP_OFF,
        o_out_data.lamp_floor == 4'd0)

    `ASSERT_NEXT(a_list_continues, i_clk, i_rst_n,
        o_out_valid && !i_out_stall && !o_out_data.last, o_out_valid)

endmodule

[bench/tb_elevator_car_controller.sv]
// ----------------------------------------------------------------------------
// tb_elevator_car_controller
// Self-checking bench for the single-car SCAN elevator controller.
// ----------------------------------------------------------------------------
// A driver feeds car events from a queue that the stimulus process fills.
// An in-bench car model predicts the motor, door and lamp commands of each
// accepted event. A monitor checks every output transaction in order against
// those predictions. The run starts with a directed sequence and then moves
// on to random traffic, made mostly of plausible trips. Each phase uses its
// own mix of sender gaps and receiver stalls. One phase holds the output off
// long enough to fill the command queue and stall the input.
// ----------------------------------------------------------------------------
module tb_elevator_car_controller import ecc_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 17;

    typedef struct {
        logic [3:0]  floor;
        logic [1:0]  dir;
        logic [15:0] stops;
    } t_car;

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_item  i_in_data   = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    t_in_item  queued_events[$];
    t_out_item pending_cmds[$];
    t_car      pred_car;
    t_car      plan_car;
    int        idle_pct  = 0;
    int        stall_pct = 0;
    int        hold_reqs = 0;
    int        hold_seen = 0;
    int        hold_left = 0;
    int        errors    = 0;
    int        cycles    = 0;

    elevator_car_controller u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void add_cmd(inout t_out_item cmds[MAX_CMDS], inout int n,
                                    input logic [2:0] c, input logic [3:0] f);
        if (n < MAX_CMDS) begin
            cmds[n] = '{command: c, lamp_floor: f, last: 1'b0};
            n++;
        end
    endfunction

    function automatic logic any_above(t_car st);
        logic [16:0] upto;
        upto = (17'd2 << st.floor) - 17'd1;
        return |(st.stops & ~upto[15:0]);
    endfunction

    function automatic logic any_below(t_car st);
        logic [15:0] below;
        below = (16'd1 << st.floor) - 16'd1;
        return |(st.stops & below);
    endfunction

    // commands caused by one event; advances the car state
    function automatic int car_step(inout t_car st, input t_in_item ev,
                                    output t_out_item cmds[MAX_CMDS]);
        logic [3:0]  fl;
        logic [15:0] bit_f;
        int          n;
        fl    = ev.floor;
        bit_f = 16'd1 << fl;
        n     = 0;
        for (int k = 0; k < MAX_CMDS; k++) cmds[k] = '0;
        case (ev.operation)
            OP_ARRIVAL: begin
                st.floor = fl;
                if (|(st.stops & bit_f)) begin
                    add_cmd(cmds, n, CMD_STOP, 4'd0);
                    add_cmd(cmds, n, CMD_OPEN, 4'd0);
                    st.stops &= ~bit_f;
                    add_cmd(cmds, n, CMD_LAMP_OFF, fl);
                    if (st.stops == '0) begin
                        add_cmd(cmds, n, CMD_STOP, 4'd0);
                        st.dir = DIR_IDLE;
                    end else if (st.dir == DIR_UP) begin
                        add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                        if (any_above(st)) begin
                            add_cmd(cmds, n, CMD_UP, 4'd0);
                        end else begin
                            st.dir = DIR_DOWN;
                            add_cmd(cmds, n, CMD_DOWN, 4'd0);
                        end
                    end else if (st.dir == DIR_DOWN) begin
                        add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                        if (any_below(st)) begin
                            add_cmd(cmds, n, CMD_DOWN, 4'd0);
                        end else begin
                            st.dir = DIR_UP;
                            add_cmd(cmds, n, CMD_UP, 4'd0);
                        end
                    end
                end else if (st.dir == DIR_UP) begin
                    add_cmd(cmds, n, CMD_UP, 4'd0);
                end else if (st.dir == DIR_DOWN) begin
                    add_cmd(cmds, n, CMD_DOWN, 4'd0);
                end
            end
            OP_HALL: begin
                st.stops |= bit_f;
                if (st.dir == DIR_IDLE) begin
                    if (fl == st.floor) begin
                        add_cmd(cmds, n, CMD_STOP, 4'd0);
                        add_cmd(cmds, n, CMD_OPEN, 4'd0);
                    end
                    add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                    if (fl > st.floor) begin
                        add_cmd(cmds, n, CMD_UP, 4'd0);
                        st.dir = DIR_UP;
                    end else begin
                        add_cmd(cmds, n, CMD_DOWN, 4'd0);
                        st.dir = DIR_DOWN;
                    end
                    add_cmd(cmds, n, CMD_LAMP_ON, fl);
                end else begin
                    add_cmd(cmds, n, CMD_LAMP_ON, fl);
                    if (fl > st.floor) begin
                        add_cmd(cmds, n, CMD_UP, 4'd0);
                        st.dir = DIR_UP;
                    end else if (fl < st.floor) begin
                        add_cmd(cmds, n, CMD_DOWN, 4'd0);
                        st.dir = DIR_DOWN;
                    end
                end
            end
            OP_CABIN: begin
                st.stops |= bit_f;
                if (st.dir == DIR_IDLE) begin
                    if (fl > st.floor) begin
                        add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                        add_cmd(cmds, n, CMD_LAMP_ON, fl);
                        add_cmd(cmds, n, CMD_UP, 4'd0);
                        st.dir = DIR_UP;
                    end else if (fl < st.floor) begin
                        add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                        add_cmd(cmds, n, CMD_LAMP_ON, fl);
                        add_cmd(cmds, n, CMD_DOWN, 4'd0);
                        st.dir = DIR_DOWN;
                    end else begin
                        add_cmd(cmds, n, CMD_STOP, 4'd0);
                        add_cmd(cmds, n, CMD_OPEN, 4'd0);
                    end
                end else if (st.dir == DIR_UP) begin
                    add_cmd(cmds, n, CMD_UP, 4'd0);
                    add_cmd(cmds, n, CMD_LAMP_ON, fl);
                end else if (st.dir == DIR_DOWN) begin
                    add_cmd(cmds, n, CMD_DOWN, 4'd0);
                    add_cmd(cmds, n, CMD_LAMP_ON, fl);
                end
            end
            default: ;
        endcase
        if (st.dir == DIR_IDLE && st.stops != '0) begin
            if (any_above(st)) begin
                add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                add_cmd(cmds, n, CMD_UP, 4'd0);
                st.dir = DIR_UP;
            end else if (any_below(st)) begin
                add_cmd(cmds, n, CMD_CLOSE, 4'd0);
                add_cmd(cmds, n, CMD_DOWN, 4'd0);
                st.dir = DIR_DOWN;
            end
        end
        if (n > 0) cmds[n-1].last = 1'b1;
        return n;
    endfunction

    function automatic t_in_item mk_event(logic [1:0] op, logic [3:0] f);
        t_in_item ev;
        ev.operation = op;
        ev.floor     = f;
        return ev;
    endfunction

    // plan_car tracks the car as of the last queued event
    task automatic queue_event(t_in_item ev);
        t_out_item dummy[MAX_CMDS];
        int        n;
        n = car_step(plan_car, ev, dummy);
        queued_events.push_back(ev);
    endtask

    // mostly trips along the current direction, plus calls and noise
    function automatic t_in_item pick_event();
        t_in_item ev;
        int       r;
        r = $urandom_range(99);
        ev.operation = OP_ARRIVAL;
        ev.floor     = 4'($urandom_range(15));
        if (r < 55 && plan_car.dir == DIR_UP && plan_car.floor != 4'd15) begin
            ev.floor = plan_car.floor + 4'd1;
        end else if (r < 55 && plan_car.dir == DIR_DOWN && plan_car.floor != 4'd0) begin
            ev.floor = plan_car.floor - 4'd1;
        end else if (r < 85) begin
            ev.operation = ($urandom_range(1) != 0) ? OP_HALL : OP_CABIN;
        end else if (r < 90) begin
            ev.operation = OP_IDLE;
        end else begin
            ev.operation = 2'($urandom_range(3));
        end
        return ev;
    endfunction

    task automatic drain();
        while (queued_events.size() != 0 || i_in_valid || pending_cmds.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic run_phase(int idle_p, int stall_p, logic hold);
        @(negedge i_clk);
        idle_pct  = idle_p;
        stall_pct = stall_p;
        if (hold) hold_reqs++;
        repeat (PHASE_ITEMS) queue_event(pick_event());
        drain();
    endtask

    // driver
    always @(posedge i_clk) begin
        logic      nxt_valid;
        t_in_item  nxt_data;
        t_out_item got[MAX_CMDS];
        int        n;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_data  <= '0;
        end else begin
            nxt_valid = i_in_valid;
            nxt_data  = i_in_data;
            if (i_in_valid && !o_in_stall) begin
                n = car_step(pred_car, i_in_data, got);
                for (int k = 0; k < n; k++) pending_cmds.push_back(got[k]);
                nxt_valid = 1'b0;
            end
            if (!nxt_valid && queued_events.size() != 0 &&
                $urandom_range(99) >= idle_pct) begin
                nxt_data  = queued_events.pop_front();
                nxt_valid = 1'b1;
            end
            i_in_valid <= nxt_valid;
            i_in_data  <= nxt_data;
        end
    end

    // long output hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_seen <= 0;
        end else if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_cmds.size() == 0) begin
                    $error("unexpected command transaction: %p", o_out_data);
                    errors++;
                end else begin
                    want = pending_cmds.pop_front();
                    if (o_out_data.command !== want.command) begin
                        $error("command: expected %0d, got %0d",
                               want.command, o_out_data.command);
                        errors++;
                    end
                    if (o_out_data.lamp_floor !== want.lamp_floor) begin
                        $error("lamp_floor: expected %0d, got %0d",
                               want.lamp_floor, o_out_data.lamp_floor);
                        errors++;
                    end
                    if (o_out_data.last !== want.last) begin
                        $error("last: expected %0d, got %0d",
                               want.last, o_out_data.last);
                        errors++;
                    end
                end
            end
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("** elevator_car_controller: FAILED **");
            $finish;
        end
    end

    initial begin
        pred_car = '{floor: 4'd0, dir: DIR_IDLE, stops: 16'd0};
        plan_car = pred_car;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed trip through the special cases
        queue_event(mk_event(OP_CABIN,   4'd0));
        queue_event(mk_event(OP_IDLE,    4'd15));
        queue_event(mk_event(OP_ARRIVAL, 4'd0));
        queue_event(mk_event(OP_HALL,    4'd0));
        queue_event(mk_event(OP_ARRIVAL, 4'd0));
        queue_event(mk_event(OP_HALL,    4'd15));
        queue_event(mk_event(OP_HALL,    4'd3));
        queue_event(mk_event(OP_CABIN,   4'd7));
        queue_event(mk_event(OP_ARRIVAL, 4'd1));
        queue_event(mk_event(OP_ARRIVAL, 4'd3));
        queue_event(mk_event(OP_ARRIVAL, 4'd7));
        queue_event(mk_event(OP_HALL,    4'd2));
        queue_event(mk_event(OP_ARRIVAL, 4'd5));
        queue_event(mk_event(OP_ARRIVAL, 4'd2));
        queue_event(mk_event(OP_ARRIVAL, 4'd15));
        queue_event(mk_event(OP_CABIN,   4'd0));
        queue_event(mk_event(OP_CABIN,   4'd9));
        queue_event(mk_event(OP_ARRIVAL, 4'd9));
        queue_event(mk_event(OP_HALL,    4'd9));
        queue_event(mk_event(OP_ARRIVAL, 4'd0));
        queue_event(mk_event(OP_ARRIVAL, 4'd9));
        queue_event(mk_event(OP_CABIN,   4'd12));
        queue_event(mk_event(OP_IDLE,    4'd0));
        queue_event(mk_event(OP_ARRIVAL, 4'd12));
        queue_event(mk_event(OP_HALL,    4'd4));
        drain();

        run_phase(0,  0,  1'b0);
        run_phase(68, 0,  1'b0);
        run_phase(0,  68, 1'b0);
        run_phase(26, 26, 1'b0);
        run_phase(0,  0,  1'b1);

        repeat (20) @(negedge i_clk);
        if (pending_cmds.size() != 0) begin
            $error("%0d expected commands never arrived", pending_cmds.size());
            errors++;
        end
        if (errors == 0) begin
            $display("** elevator_car_controller: PASSED **");
        end else begin
            $display("** elevator_car_controller: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ecc_pkg.sv
rtl/ecc_front.sv
rtl/ecc_queue.sv
rtl/ecc_back.sv
rtl/elevator_car_controller.sv
bench/tb_elevator_car_controller.sv
